### rtl/thermal_level_hysteresis_debounce_macros.svh
// Assertion macros for the RTL. The enclosing module supplies clk and rst.
`ifndef THERMAL_LEVEL_HYSTERESIS_DEBOUNCE_MACROS_SVH
`define THERMAL_LEVEL_HYSTERESIS_DEBOUNCE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TLHD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tlhd assertion failed");

// Next-cycle implication.
`define TLHD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tlhd assertion failed");

`else

`define TLHD_ASSERT_NOW(label, ante, cons)
`define TLHD_ASSERT_NEXT(label, ante, cons)

`endif

`endif

### rtl/tlhd_pkg.sv
package tlhd_pkg;

  localparam int TIME_WIDTH = 48;
  localparam int TEMP_WIDTH = 18;
  localparam int DWELL_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 3;

  localparam int HYST_DEADBAND = 3000;
  localparam int NEAR_CRIT_BAND = 5000;

  localparam logic [9:0] RED_NORMAL = 10'd0;
  localparam logic [9:0] RED_WARN = 10'd150;
  localparam logic [9:0] RED_THROTTLE = 10'd300;
  localparam logic [9:0] RED_NEAR_CRIT = 10'd500;
  localparam logic [9:0] RED_CRIT = 10'd800;

  localparam logic [TEMP_WIDTH-1:0] WARN_THR_RESET = 18'd70000;
  localparam logic [TEMP_WIDTH-1:0] THROTTLE_THR_RESET = 18'd80000;
  localparam logic [TEMP_WIDTH-1:0] CRIT_THR_RESET = 18'd95000;
  localparam logic [TEMP_WIDTH-1:0] RECOVERY_THR_RESET = 18'd75000;
  localparam logic [DWELL_WIDTH-1:0] COOL_DWELL_RESET = 16'd2000;
  localparam logic [DWELL_WIDTH-1:0] HOT_DWELL_RESET = 16'd500;
  localparam logic [DWELL_WIDTH-1:0] WARN_DWELL_RESET = 16'd1000;

  typedef enum logic [1:0] {
    LVL_NORMAL = 2'd0,
    LVL_WARN = 2'd1,
    LVL_THROTTLE = 2'd2,
    LVL_CRIT = 2'd3
  } level_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_WARN_THR = 3'd0,
    REG_THROTTLE_THR = 3'd1,
    REG_CRIT_THR = 3'd2,
    REG_RECOVERY_THR = 3'd3,
    REG_COOL_DWELL = 3'd4,
    REG_HOT_DWELL = 3'd5,
    REG_WARN_DWELL = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [18:0] hottest_temp;
    logic [47:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0] thermal_level;
    logic level_changed;
    logic [TEMP_WIDTH-1:0] clamped_temp;
    logic [9:0] reduction_permille;
  } out_t;

  typedef struct packed {
    logic [TEMP_WIDTH-1:0] warn_threshold;
    logic [TEMP_WIDTH-1:0] throttle_threshold;
    logic [TEMP_WIDTH-1:0] critical_threshold;
    logic [TEMP_WIDTH-1:0] recovery_threshold;
    logic [DWELL_WIDTH-1:0] cool_dwell_ms;
    logic [DWELL_WIDTH-1:0] hot_dwell_ms;
    logic [DWELL_WIDTH-1:0] warn_dwell_ms;
  } cfg_t;

  typedef struct packed {
    level_t current_level;
    level_t pending_level;
    logic [TIME_WIDTH-1:0] pending_time;
    logic pending_valid;
  } state_t;

endpackage

### rtl/thermal_level_hysteresis_debounce.sv
// Channel | Direction | Payload            | Handshake
// in      | input     | tlhd_pkg::in_t     | in_valid / in_ready
// out     | output    | tlhd_pkg::out_t    | out_valid / out_ready
// cfg     | input     | cfg_index,cfg_data | cfg_valid / cfg_ready (always ready)
//
// One word per cycle unless the output stalls, limited by the level feedback loop; a word
// passes the input register, then the result register, before its result appears.
// Synchronous reset restores the threshold and dwell defaults, level normal, no timer.
// A stalled output holds the input register; in_ready drops only while both are full.
`include "thermal_level_hysteresis_debounce_macros.svh"

module thermal_level_hysteresis_debounce (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  tlhd_pkg::in_t                           in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output tlhd_pkg::out_t                          out_data,
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [tlhd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
  input  logic [tlhd_pkg::TEMP_WIDTH-1:0]         cfg_data
);

  tlhd_pkg::cfg_t   cfg;
  tlhd_pkg::state_t st;
  tlhd_pkg::state_t st_next;
  tlhd_pkg::out_t   result;
  tlhd_pkg::in_t    s1_data;
  logic             s1_valid;
  logic             s1_advance;

  assign cfg_ready = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.warn_threshold <= tlhd_pkg::WARN_THR_RESET;
      cfg.throttle_threshold <= tlhd_pkg::THROTTLE_THR_RESET;
      cfg.critical_threshold <= tlhd_pkg::CRIT_THR_RESET;
      cfg.recovery_threshold <= tlhd_pkg::RECOVERY_THR_RESET;
      cfg.cool_dwell_ms <= tlhd_pkg::COOL_DWELL_RESET;
      cfg.hot_dwell_ms <= tlhd_pkg::HOT_DWELL_RESET;
      cfg.warn_dwell_ms <= tlhd_pkg::WARN_DWELL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (tlhd_pkg::cfg_reg_t'(cfg_index))
        tlhd_pkg::REG_WARN_THR:     cfg.warn_threshold <= cfg_data;
        tlhd_pkg::REG_THROTTLE_THR: cfg.throttle_threshold <= cfg_data;
        tlhd_pkg::REG_CRIT_THR:     cfg.critical_threshold <= cfg_data;
        tlhd_pkg::REG_RECOVERY_THR: cfg.recovery_threshold <= cfg_data;
        tlhd_pkg::REG_COOL_DWELL:   cfg.cool_dwell_ms <= cfg_data[tlhd_pkg::DWELL_WIDTH-1:0];
        tlhd_pkg::REG_HOT_DWELL:    cfg.hot_dwell_ms <= cfg_data[tlhd_pkg::DWELL_WIDTH-1:0];
        tlhd_pkg::REG_WARN_DWELL:   cfg.warn_dwell_ms <= cfg_data[tlhd_pkg::DWELL_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
  end

  tlhd_decide u_decide (
    .cfg     (cfg),
    .st      (st),
    .sample  (s1_data),
    .st_next (st_next),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.current_level <= tlhd_pkg::LVL_NORMAL;
      st.pending_level <= tlhd_pkg::LVL_NORMAL;
      st.pending_time <= '0;
      st.pending_valid <= 1'b0;
    end else if (s1_advance) begin
      st <= st_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= result;
    end
  end

  `TLHD_ASSERT_NEXT(a_out_tracks_level, s1_advance,
    out_valid && out_data.thermal_level == st.current_level)
  `TLHD_ASSERT_NOW(a_pending_differs, st.pending_valid,
    st.pending_level != st.current_level)
  `TLHD_ASSERT_NOW(a_no_crit_pending, st.pending_valid,
    st.pending_level != tlhd_pkg::LVL_CRIT)
  `TLHD_ASSERT_NEXT(a_s1_holds, s1_valid && !s1_advance,
    s1_valid && $stable(s1_data))

endmodule

### rtl/tlhd_decide.sv
module tlhd_decide (
  input  tlhd_pkg::cfg_t   cfg,
  input  tlhd_pkg::state_t st,
  input  tlhd_pkg::in_t    sample,
  output tlhd_pkg::state_t st_next,
  output tlhd_pkg::out_t   result
);

  logic [tlhd_pkg::TEMP_WIDTH-1:0] t;
  logic [tlhd_pkg::TEMP_WIDTH:0] t_ext;
  logic [tlhd_pkg::TEMP_WIDTH:0] t_hyst;
  logic [tlhd_pkg::TEMP_WIDTH:0] t_near;
  logic [tlhd_pkg::TIME_WIDTH-1:0] now;
  logic [tlhd_pkg::TIME_WIDTH-1:0] elapsed;
  logic [tlhd_pkg::DWELL_WIDTH-1:0] dwell;
  tlhd_pkg::level_t measured;
  tlhd_pkg::level_t proposed;
  tlhd_pkg::level_t cur;
  tlhd_pkg::level_t lvl;
  logic restart;

  // Negative samples read as zero.
  assign t = sample.hottest_temp[18] ? '0 : sample.hottest_temp[tlhd_pkg::TEMP_WIDTH-1:0];
  assign t_ext = {1'b0, t};
  // Compare t + band >= threshold so that a small threshold cannot wrap.
  assign t_hyst = t_ext + (tlhd_pkg::TEMP_WIDTH+1)'(tlhd_pkg::HYST_DEADBAND);
  assign t_near = t_ext + (tlhd_pkg::TEMP_WIDTH+1)'(tlhd_pkg::NEAR_CRIT_BAND);
  assign now = sample.now_ms[tlhd_pkg::TIME_WIDTH-1:0];
  assign elapsed = now - st.pending_time;
  assign cur = st.current_level;

  always_comb begin
    if (t >= cfg.critical_threshold) begin
      measured = tlhd_pkg::LVL_CRIT;
    end else if (t >= cfg.throttle_threshold) begin
      measured = tlhd_pkg::LVL_THROTTLE;
    end else if (t >= cfg.warn_threshold) begin
      measured = tlhd_pkg::LVL_WARN;
    end else begin
      measured = tlhd_pkg::LVL_NORMAL;
    end
  end

  always_comb begin
    if (measured >= cur) begin
      proposed = measured;
    end else if (cur == tlhd_pkg::LVL_CRIT && t_hyst >= {1'b0, cfg.critical_threshold}) begin
      proposed = tlhd_pkg::LVL_CRIT;
    end else if (cur >= tlhd_pkg::LVL_THROTTLE && measured < tlhd_pkg::LVL_THROTTLE &&
                 t >= cfg.recovery_threshold) begin
      proposed = tlhd_pkg::LVL_THROTTLE;
    end else if (cur >= tlhd_pkg::LVL_WARN && measured == tlhd_pkg::LVL_NORMAL &&
                 t_hyst >= {1'b0, cfg.warn_threshold}) begin
      proposed = tlhd_pkg::LVL_WARN;
    end else begin
      proposed = measured;
    end
  end

  always_comb begin
    if (proposed < cur) begin
      dwell = cfg.cool_dwell_ms;
    end else if (proposed >= tlhd_pkg::LVL_THROTTLE) begin
      dwell = cfg.hot_dwell_ms;
    end else begin
      dwell = cfg.warn_dwell_ms;
    end
  end

  assign restart = (st.pending_level != proposed) || !st.pending_valid ||
                   (now < st.pending_time);

  always_comb begin
    st_next = st;
    lvl = cur;
    if (proposed == cur) begin
      st_next.pending_level = cur;
      st_next.pending_valid = 1'b0;
    end else if (proposed == tlhd_pkg::LVL_CRIT) begin
      // Critical skips the dwell.
      st_next.pending_level = proposed;
      st_next.pending_valid = 1'b0;
      lvl = proposed;
    end else if (restart) begin
      st_next.pending_level = proposed;
      st_next.pending_time = now;
      st_next.pending_valid = 1'b1;
    end else if (elapsed >= {{(tlhd_pkg::TIME_WIDTH-tlhd_pkg::DWELL_WIDTH){1'b0}}, dwell}) begin
      st_next.pending_level = proposed;
      st_next.pending_valid = 1'b0;
      lvl = proposed;
    end
    st_next.current_level = lvl;
  end

  always_comb begin
    result.thermal_level = lvl;
    result.level_changed = (lvl != cur);
    result.clamped_temp = t;
    case (lvl)
      tlhd_pkg::LVL_WARN:     result.reduction_permille = tlhd_pkg::RED_WARN;
      tlhd_pkg::LVL_THROTTLE: result.reduction_permille =
          (t_near >= {1'b0, cfg.critical_threshold}) ? tlhd_pkg::RED_NEAR_CRIT
                                                      : tlhd_pkg::RED_THROTTLE;
      tlhd_pkg::LVL_CRIT:     result.reduction_permille = tlhd_pkg::RED_CRIT;
      default:                result.reduction_permille = tlhd_pkg::RED_NORMAL;
    endcase
  end

endmodule
